// ===== rtl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// shared types and constants of the depth to color registration core
// ----------------------------------------------------------------------------
package drc_pkg;

	// stream field widths
	localparam int PX_W      = 10;
	localparam int PY_W      = 9;
	localparam int DEPTH_W   = 16;
	localparam int CH_W      = 8;
	localparam int RGB_W     = 3 * CH_W;
	localparam int ST_W      = 2;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = RGB_W;

	// configuration registers
	localparam int CFG_W    = 64;
	localparam int COEF_W   = 32;
	localparam int NUM_REGS = 6;
	localparam int NUM_ROWS = 3;
	localparam int IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_ROW0_FIRST  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_SECOND = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_FIRST  = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_SECOND = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_FIRST  = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_SECOND = 3'd5;

	// fixed point: z is unsigned q4.16, map rows are exact q.32
	localparam int FRAC_W  = 16;
	localparam int Z_W     = 20;
	localparam int N_W     = DEPTH_W + FRAC_W;
	localparam int ZR_W    = 31;
	localparam int ZP_W    = N_W + ZR_W;
	localparam int Z_SHIFT = 40;
	localparam int ZE_W    = ZP_W - Z_SHIFT;
	localparam int PROD_W  = COEF_W + PX_W + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam int T_W     = 64;

	localparam logic [ZR_W-1:0] Z_RECIP  = 31'd1099511627;  // floor(2^40 / 1000)
	localparam logic [N_W-1:0]  MM_PER_M = 32'd1000;
	localparam logic [N_W-1:0]  Z_ROUND  = 32'd500;
	localparam logic [Z_W-1:0]  Z_MAX    = 20'hFFFFF;

	localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

	// result status codes
	localparam logic [ST_W-1:0] ST_COLORED = 2'd0;
	localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd1;
	localparam logic [ST_W-1:0] ST_NODEPTH = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CONST = 2'd2
	} op_kind_t;

	// work item handed from the front end to the back end
	typedef struct packed {
		op_kind_t          kind;
		logic [ST_W-1:0]   status;
		logic [RGB_W-1:0]  rgb;     // red in the high byte
	} drc_cmd_t;

endpackage

// ===== rtl/drc_ram.sv =====
// ----------------------------------------------------------------------------
// drc_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module drc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 307200
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/drc_div.sv =====
// ----------------------------------------------------------------------------
// drc_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module drc_div
	import drc_pkg::*;
#(
	parameter int QB = 10
) (
	input  logic           clk,
	input  logic           en,
	input  logic [T_W-1:0] num,
	input  logic [T_W-1:0] den,
	output logic [QB-1:0]  quo,
	output logic           ovf
);

	localparam int RW = T_W + QB;

	logic [RW-1:0]  rem_q [QB];
	logic [T_W-1:0] den_q [QB];
	logic [QB-1:0]  quo_q [QB];
	logic           ovf_q [QB];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_stage
			logic [RW-1:0]  rem_in;
			logic [T_W-1:0] den_in;
			logic [QB-1:0]  quo_in;
			logic           ovf_in;
			logic [RW-1:0]  dsh;
			logic           ge;
			logic [QB-1:0]  quo_nx;

			if (k == 0) begin : g_first
				// quotient needs more than QB bits, or divide by zero
				assign rem_in = RW'(num);
				assign den_in = den;
				assign quo_in = '0;
				assign ovf_in = RW'(num) >= (RW'(den) << QB);
			end else begin : g_next
				assign rem_in = rem_q[k-1];
				assign den_in = den_q[k-1];
				assign quo_in = quo_q[k-1];
				assign ovf_in = ovf_q[k-1];
			end

			assign dsh = RW'(den_in) << (QB - 1 - k);
			assign ge  = rem_in >= dsh;

			always_comb begin
				quo_nx = quo_in;
				quo_nx[QB-1-k] = ge;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? (rem_in - dsh) : rem_in;
					den_q[k] <= den_in;
					quo_q[k] <= quo_nx;
					ovf_q[k] <= ovf_in;
				end
			end
		end
	endgenerate

	assign quo = quo_q[QB-1];
	assign ovf = ovf_q[QB-1];

endmodule

// ===== rtl/drc_front.sv =====
// ----------------------------------------------------------------------------
// drc_front
// coefficient registers, projective map pipeline, classification of items
// ----------------------------------------------------------------------------
module drc_front
	import drc_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_cmd,
	input  logic [PX_W-1:0]          in_px,
	input  logic [PY_W-1:0]          in_py,
	input  logic [DEPTH_W-1:0]       in_depth,
	input  logic [RGB_W-1:0]         in_rgb,
	input  logic                     q_full,
	output logic                     q_push,
	output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0] q_addr,
	output drc_cmd_t                 q_cmd
);

	localparam int QB = $clog2((IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT);
	localparam int AW = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT);

	typedef struct packed {
		logic             cmd;
		logic             nodep;
		logic             neg_col;
		logic             neg_row;
		logic [PX_W-1:0]  px;
		logic [PY_W-1:0]  py;
		logic [RGB_W-1:0] rgb;
	} side_t;

	function automatic logic [T_W-1:0] mag_of(input logic signed [T_W-1:0] v);
		mag_of = v[T_W-1] ? ((~v) + T_W'(1)) : v;
	endfunction

	// coefficient registers
	logic [CFG_W-1:0] coef_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index < IDX_W'(NUM_REGS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	logic signed [COEF_W-1:0] a1 [NUM_ROWS];
	logic signed [COEF_W-1:0] a2 [NUM_ROWS];
	logic signed [COEF_W-1:0] a3 [NUM_ROWS];
	logic signed [COEF_W-1:0] a4 [NUM_ROWS];

	always_comb begin
		a1[0] = coef_q[REG_ROW0_FIRST][COEF_W-1:0];
		a2[0] = coef_q[REG_ROW0_FIRST][CFG_W-1:COEF_W];
		a3[0] = coef_q[REG_ROW0_SECOND][COEF_W-1:0];
		a4[0] = coef_q[REG_ROW0_SECOND][CFG_W-1:COEF_W];
		a1[1] = coef_q[REG_ROW1_FIRST][COEF_W-1:0];
		a2[1] = coef_q[REG_ROW1_FIRST][CFG_W-1:COEF_W];
		a3[1] = coef_q[REG_ROW1_SECOND][COEF_W-1:0];
		a4[1] = coef_q[REG_ROW1_SECOND][CFG_W-1:COEF_W];
		a1[2] = coef_q[REG_ROW2_FIRST][COEF_W-1:0];
		a2[2] = coef_q[REG_ROW2_FIRST][CFG_W-1:COEF_W];
		a3[2] = coef_q[REG_ROW2_SECOND][COEF_W-1:0];
		a4[2] = coef_q[REG_ROW2_SECOND][CFG_W-1:COEF_W];
	end

	// whole pipeline moves together, held only when the last stage cannot push
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic vld_q [QB];
	logic en;

	assign en       = !(vld_q[QB-1] && q_full);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int k = 0; k < QB; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_q[0] <= vld_s4;
			for (int k = 1; k < QB; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// s1: coefficient products and reciprocal product for z
	logic [N_W-1:0]           zn_in;
	logic                     cmd_s1;
	logic [PX_W-1:0]          px_s1;
	logic [PY_W-1:0]          py_s1;
	logic [DEPTH_W-1:0]       depth_s1;
	logic [RGB_W-1:0]         rgb_s1;
	logic signed [PROD_W-1:0] p1_s1 [NUM_ROWS];
	logic signed [PROD_W-1:0] p2_s1 [NUM_ROWS];
	logic [ZP_W-1:0]          zp_s1;

	assign zn_in = {in_depth, {FRAC_W{1'b0}}} + Z_ROUND;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= in_cmd;
			px_s1    <= in_px;
			py_s1    <= in_py;
			depth_s1 <= in_depth;
			rgb_s1   <= in_rgb;
			zp_s1    <= ZP_W'(zn_in) * ZP_W'(Z_RECIP);
			for (int r = 0; r < NUM_ROWS; r++) begin
				p1_s1[r] <= a1[r] * $signed({1'b0, in_px});
				p2_s1[r] <= a2[r] * $signed({1'b0, in_py});
			end
		end
	end

	// s2: row sums, z with one correction step and saturation
	logic [N_W-1:0]          zn1, zmul, zrem;
	logic [ZE_W-1:0]         zest, zc;
	logic [Z_W-1:0]          z_nx;
	logic                    cmd_s2, nodep_s2;
	logic [PX_W-1:0]         px_s2;
	logic [PY_W-1:0]         py_s2;
	logic [RGB_W-1:0]        rgb_s2;
	logic [Z_W-1:0]          z_s2;
	logic signed [SUM_W-1:0] sum_s2 [NUM_ROWS];

	always_comb begin
		zn1  = {depth_s1, {FRAC_W{1'b0}}} + Z_ROUND;
		zest = zp_s1[ZP_W-1:Z_SHIFT];
		zmul = N_W'(zest) * MM_PER_M;
		zrem = zn1 - zmul;
		zc   = zest + ZE_W'(zrem >= MM_PER_M);
		z_nx = (zc > ZE_W'(Z_MAX)) ? Z_MAX : zc[Z_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= cmd_s1;
			nodep_s2 <= (depth_s1 == '0);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			rgb_s2   <= rgb_s1;
			z_s2     <= z_nx;
			for (int r = 0; r < NUM_ROWS; r++) begin
				sum_s2[r] <= SUM_W'(p1_s1[r]) + SUM_W'(p2_s1[r]) + SUM_W'(a3[r]);
			end
		end
	end

	// s3: t = sum * z + a4 * 2^16
	logic                  cmd_s3, nodep_s3;
	logic [PX_W-1:0]       px_s3;
	logic [PY_W-1:0]       py_s3;
	logic [RGB_W-1:0]      rgb_s3;
	logic signed [T_W-1:0] t_s3 [NUM_ROWS];
	logic signed [T_W-1:0] a4w  [NUM_ROWS];

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			a4w[r] = {{(T_W-COEF_W-FRAC_W){a4[r][COEF_W-1]}}, a4[r], {FRAC_W{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3   <= cmd_s2;
			nodep_s3 <= nodep_s2;
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			rgb_s3   <= rgb_s2;
			for (int r = 0; r < NUM_ROWS; r++) begin
				t_s3[r] <= sum_s2[r] * $signed({1'b0, z_s2}) + a4w[r];
			end
		end
	end

	// s4: magnitudes and quotient signs
	side_t          side_s4;
	logic [T_W-1:0] mag_s4 [NUM_ROWS];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.cmd     <= cmd_s3;
			side_s4.nodep   <= nodep_s3;
			side_s4.neg_col <= t_s3[0][T_W-1] ^ t_s3[2][T_W-1];
			side_s4.neg_row <= t_s3[1][T_W-1] ^ t_s3[2][T_W-1];
			side_s4.px      <= px_s3;
			side_s4.py      <= py_s3;
			side_s4.rgb     <= rgb_s3;
			for (int r = 0; r < NUM_ROWS; r++) begin
				mag_s4[r] <= mag_of(t_s3[r]);
			end
		end
	end

	// dividers, side information travels alongside
	logic [QB-1:0] col, row;
	logic          col_ovf, row_ovf;
	side_t         side_q [QB];

	drc_div #(.QB(QB)) u_div_col (
		.clk (clk),
		.en  (en),
		.num (mag_s4[0]),
		.den (mag_s4[2]),
		.quo (col),
		.ovf (col_ovf)
	);

	drc_div #(.QB(QB)) u_div_row (
		.clk (clk),
		.en  (en),
		.num (mag_s4[1]),
		.den (mag_s4[2]),
		.quo (row),
		.ovf (row_ovf)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s4;
			for (int k = 1; k < QB; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// classification
	side_t sd;
	logic  outside, st_in, keep;

	always_comb begin
		sd      = side_q[QB-1];
		outside = col_ovf || row_ovf
		       || (sd.neg_col && (col != '0)) || (sd.neg_row && (row != '0))
		       || (int'(col) >= IMAGE_WIDTH) || (int'(row) >= IMAGE_HEIGHT);
		st_in   = (int'(sd.px) < IMAGE_WIDTH) && (int'(sd.py) < IMAGE_HEIGHT);
		keep    = sd.cmd || st_in;

		q_cmd.rgb    = sd.rgb;
		q_cmd.status = ST_COLORED;
		q_addr       = AW'(row) * AW'(IMAGE_WIDTH) + AW'(col);
		if (!sd.cmd) begin
			q_cmd.kind = OP_WRITE;
			q_addr     = AW'(sd.py) * AW'(IMAGE_WIDTH) + AW'(sd.px);
		end else if (sd.nodep) begin
			q_cmd.kind   = OP_CONST;
			q_cmd.status = ST_NODEPTH;
			q_cmd.rgb    = {CH_FULL, CH_FULL, CH_FULL};
		end else if (outside) begin
			q_cmd.kind   = OP_CONST;
			q_cmd.status = ST_OUTSIDE;
			q_cmd.rgb    = '0;
		end else begin
			q_cmd.kind = OP_READ;
		end
	end

	assign q_push = en && vld_q[QB-1] && keep;

endmodule

// ===== rtl/drc_fifo.sv =====
// ----------------------------------------------------------------------------
// drc_fifo
// short queue between front end and back end
// ----------------------------------------------------------------------------
module drc_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : (wr_q + PW'(1));
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : (rd_q + PW'(1));
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue popped while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/drc_back.sv =====
// ----------------------------------------------------------------------------
// drc_back
// color frame store access and result output register
// ----------------------------------------------------------------------------
module drc_back
	import drc_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0] q_addr,
	input  drc_cmd_t                 q_cmd,
	output logic                     m_valid,
	input  logic                     m_ready,
	output logic [RGB_W-1:0]         m_rgb,
	output logic [ST_W-1:0]          m_status
);

	localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;

	logic             out_adv, b1_adv;
	logic             vld_s1;
	op_kind_t         kind_s1;
	logic [ST_W-1:0]  status_s1;
	logic [RGB_W-1:0] rgb_s1;
	logic [RGB_W-1:0] rdata;
	logic             m_valid_q;
	logic [RGB_W-1:0] m_rgb_q;
	logic [ST_W-1:0]  m_status_q;

	assign out_adv = !m_valid_q || m_ready;
	assign b1_adv  = !vld_s1 || out_adv;
	assign q_pop   = b1_adv && !q_empty;

	drc_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_frame (
		.clk   (clk),
		.we    (q_pop && (q_cmd.kind == OP_WRITE)),
		.waddr (q_addr),
		.wdata (q_cmd.rgb),
		.re    (q_pop && (q_cmd.kind == OP_READ)),
		.raddr (q_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (b1_adv) begin
				vld_s1 <= q_pop && (q_cmd.kind != OP_WRITE);
			end
			if (out_adv) begin
				m_valid_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b1_adv) begin
			kind_s1   <= q_cmd.kind;
			status_s1 <= q_cmd.status;
			rgb_s1    <= q_cmd.rgb;
		end
		if (out_adv) begin
			m_rgb_q    <= (kind_s1 == OP_READ) ? rdata : rgb_s1;
			m_status_q <= status_s1;
		end
	end

	assign m_valid  = m_valid_q;
	assign m_rgb    = m_rgb_q;
	assign m_status = m_status_q;

endmodule

// ===== rtl/depth_to_color_registration_core.sv =====
// ----------------------------------------------------------------------------
// depth_to_color_registration_core
// colors depth pixels from a stored color frame through a 3x4 projective map
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one word per item; s_tuser = 0 stores a color pixel into the
//   frame store, s_tuser = 1 reconstructs one depth pixel. stores give no
//   result, every reconstruct gives exactly one m_* word, in input order.
//   cfg_*: six 64-bit coefficient pair registers, written while the core is
//   idle; cfg_ready is always high.
//   throughput: one word per cycle on both sides while m_tready is high.
//   from s accept to m_tvalid a word passes the front end stages, the
//   one-bit-per-stage divider pipeline for QB = clog2(max(W, H)) quotient bits,
//   the front/back queue, the frame store read and the output register.
//   reset: coefficients clear to zero, pipeline and queue empty; the frame
//   store holds garbage until written and is never cleared.
//   when m_tready is low the result waits in the output register, the back
//   end and queue fill, and s_tready drops only once the queue is full.
// ----------------------------------------------------------------------------
module depth_to_color_registration_core
	import drc_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // pixel_x, pixel_y, depth_mm, color_red,
	                                        // color_green, color_blue, zero pad
	input  logic                 s_tuser,   // command
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // out_red, out_green, out_blue
	output logic [ST_W-1:0]      m_tuser,   // pixel_status
	// coefficient writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW      = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT);
	localparam int CMD_W   = $bits(drc_cmd_t);
	localparam int Q_W     = AW + CMD_W;
	localparam int Q_DEPTH = 4;

	// input word fields
	localparam int PY_LSB = PX_W;
	localparam int D_LSB  = PY_LSB + PY_W;
	localparam int R_LSB  = D_LSB + DEPTH_W;
	localparam int G_LSB  = R_LSB + CH_W;
	localparam int B_LSB  = G_LSB + CH_W;

	logic             f_push, q_full, q_empty, q_pop;
	logic [AW-1:0]    f_addr, b_addr;
	drc_cmd_t         f_cmd, b_cmd;
	logic [Q_W-1:0]   q_dout;
	logic [RGB_W-1:0] m_rgb;

	// coefficients are writable at any time the core is idle
	assign cfg_ready = 1'b1;

	drc_front #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_px     (s_tdata[PX_W-1:0]),
		.in_py     (s_tdata[PY_LSB +: PY_W]),
		.in_depth  (s_tdata[D_LSB +: DEPTH_W]),
		// frame store keeps red in the high byte
		.in_rgb    ({s_tdata[R_LSB +: CH_W], s_tdata[G_LSB +: CH_W],
		             s_tdata[B_LSB +: CH_W]}),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_addr    (f_addr),
		.q_cmd     (f_cmd)
	);

	// decouples the fixed pipeline from frame store and output stalls
	drc_fifo #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    ({f_addr, f_cmd}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign b_addr = q_dout[Q_W-1:CMD_W];
	assign b_cmd  = q_dout[CMD_W-1:0];

	drc_back #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_addr   (b_addr),
		.q_cmd    (b_cmd),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_rgb    (m_rgb),
		.m_status (m_tuser)
	);

	// red in the lowest byte of the result word
	assign m_tdata = {m_rgb[CH_W-1:0], m_rgb[2*CH_W-1:CH_W], m_rgb[RGB_W-1:2*CH_W]};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking stream test of depth_to_color_registration_core: color
// stores and depth reconstructs go in under several coefficient settings,
// each result word is checked against an in-bench projection and frame model
// ----------------------------------------------------------------------------
module testbench
	import drc_pkg::*;
();

	localparam int IMG_W     = 640;
	localparam int IMG_H     = 480;
	localparam bit CMD_STORE = 1'b0;
	localparam bit CMD_RECON = 1'b1;
	localparam int DRAIN_CYC = 40;         // margin well above the core's input to output delay
	localparam int CYC_LIMIT = 600000;
	localparam int HOLD_CYC  = 400;        // long receiver hold-off
	localparam int HOLD_AT   = 1250;       // words accepted before the hold-off

	typedef struct {
		bit         cmd;
		bit [9:0]   x;
		bit [8:0]   y;
		bit [15:0]  depth;
		bit [7:0]   r, g, b;
	} pixel_t;

	typedef struct {
		bit [7:0]        r, g, b;
		bit [ST_W-1:0]   st;
	} color_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]      m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	depth_to_color_registration_core #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H)
	) DUT (.*);

	// shared state of generator, predictor and checker
	pixel_t     pixel_queue[$];            // words waiting for the driver
	color_t     color_due[$];              // expected result words, oldest first
	bit [63:0]  coef_regs[NUM_REGS];       // current coefficient pairs
	bit [23:0]  frame_model[int];          // predictor copy of the frame store
	bit         gen_written[int];          // entries the generator has stored
	pixel_t     on_bus;
	int         n_in = 0;
	int         cyc = 0;
	int         hold_cnt = 0;
	bit         hold_done = 1'b0;
	bit         failed = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// signed q15.16 coefficient: row r, column k (0..3)
	function automatic longint coef(int r, int k);
		bit [63:0] pair;
		pair = coef_regs[r * 2 + k / 2];
		return longint'($signed(pair[(k % 2) * 32 +: 32]));
	endfunction

	// projective map of one depth pixel; col/row only valid with ST_COLORED
	function automatic void project(pixel_t p, output bit [ST_W-1:0] st,
	                                output int col, output int row);
		longint z, t[3], s;
		col = 0;
		row = 0;
		if (p.depth == 0) begin
			st = ST_NODEPTH;
			return;
		end
		z = (longint'(p.depth) * 65536 + 500) / 1000;
		if (z > 64'hFFFFF) z = 64'hFFFFF;
		for (int r = 0; r < 3; r++) begin
			s = coef(r, 0) * longint'(p.x) + coef(r, 1) * longint'(p.y) + coef(r, 2);
			t[r] = s * z + coef(r, 3) * 65536;
		end
		if (t[2] == 0) begin
			st = ST_OUTSIDE;
			return;
		end
		// longint division truncates toward zero
		if (t[0] / t[2] < 0 || t[0] / t[2] >= IMG_W ||
		    t[1] / t[2] < 0 || t[1] / t[2] >= IMG_H) begin
			st = ST_OUTSIDE;
			return;
		end
		col = int'(t[0] / t[2]);
		row = int'(t[1] / t[2]);
		st  = ST_COLORED;
	endfunction

	// expected word for a reconstruct, updates the frame copy for a store
	function automatic void color_of_pixel(pixel_t p);
		color_t     c;
		bit [ST_W-1:0] st;
		int         col, row;
		if (p.cmd == CMD_STORE) begin
			if (p.x < IMG_W && p.y < IMG_H)
				frame_model[p.y * IMG_W + p.x] = {p.r, p.g, p.b};
			return;
		end
		project(p, st, col, row);
		c.st = st;
		case (st)
			ST_NODEPTH: {c.r, c.g, c.b} = {CH_FULL, CH_FULL, CH_FULL};
			ST_COLORED: {c.r, c.g, c.b} = frame_model[row * IMG_W + col];
			default:    {c.r, c.g, c.b} = '0;
		endcase
		color_due.insert(color_due.size(), c);
	endfunction

	// queue a word; a reconstruct that lands on a never stored entry gets
	// a store there first, so the unwritten frame content is never read
	task automatic add_pixel(pixel_t p);
		pixel_t     fill;
		bit [ST_W-1:0] st;
		int         col, row;
		if (p.cmd == CMD_RECON) begin
			project(p, st, col, row);
			if (st == ST_COLORED && !gen_written.exists(row * IMG_W + col)) begin
				fill.cmd   = CMD_STORE;
				fill.x     = 10'(col);
				fill.y     = 9'(row);
				fill.depth = 16'($urandom);
				fill.r     = 8'($urandom);
				fill.g     = 8'($urandom);
				fill.b     = 8'($urandom);
				gen_written[row * IMG_W + col] = 1'b1;
				pixel_queue.insert(pixel_queue.size(), fill);
			end
		end else if (p.x < IMG_W && p.y < IMG_H) begin
			gen_written[p.y * IMG_W + p.x] = 1'b1;
		end
		pixel_queue.insert(pixel_queue.size(), p);
	endtask

	task automatic add_fields(bit cmd, int x, int y, int depth);
		pixel_t p;
		p.cmd   = cmd;
		p.x     = 10'(x);
		p.y     = 9'(y);
		p.depth = 16'(depth);
		p.r     = 8'($urandom);
		p.g     = 8'($urandom);
		p.b     = 8'($urandom);
		add_pixel(p);
	endtask

	// random word: mostly reconstructs inside the frame at plausible depths
	task automatic add_random(int n);
		int sel, x, y, d;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			x   = (sel % 10 == 0) ? $urandom_range(1023) : $urandom_range(IMG_W - 1);
			y   = (sel % 10 == 0) ? $urandom_range(511)  : $urandom_range(IMG_H - 1);
			case ($urandom_range(9))
				0:       d = 0;
				1:       d = $urandom_range(65535, 16000);
				default: d = $urandom_range(8000, 1);
			endcase
			add_fields(sel < 30 ? CMD_STORE : CMD_RECON, x, y, d);
		end
	endtask

	task automatic write_reg(int idx, bit [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= IDX_W'(idx);
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS) coef_regs[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for the core to empty out before touching the coefficients
	task automatic drain();
		while (pixel_queue.size() || s_tvalid || color_due.size()) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// near-identity map with a random skew and offset
	task automatic set_identity_like();
		write_reg(REG_ROW0_FIRST,  {32'($urandom_range(2000)),
		                           32'(65536 + $urandom_range(4000) - 2000)});
		write_reg(REG_ROW0_SECOND, {32'($urandom_range(32'h80000)),
		                           32'($urandom_range(4000) - 2000)});
		write_reg(REG_ROW1_FIRST,  {32'(65536 + $urandom_range(4000) - 2000),
		                           32'($urandom_range(2000))});
		write_reg(REG_ROW1_SECOND, {32'($urandom_range(32'h80000)),
		                           32'($urandom_range(4000) - 2000)});
		write_reg(REG_ROW2_FIRST,  {32'($urandom_range(20) - 10), 32'($urandom_range(20) - 10)});
		write_reg(REG_ROW2_SECOND, {32'($urandom_range(32'h10000)), 32'(65536)});
	endtask

	function automatic bit [31:0] extreme_coef();
		case ($urandom_range(4))
			0:       return 32'h0000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return 32'h0001_0000;
		endcase
	endfunction

	// stimulus: one phase per coefficient setting
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: every reconstruct with nonzero depth hits a zero denominator
		add_fields(CMD_RECON, 0, 0, 1000);
		add_fields(CMD_RECON, 1023, 511, 65535);
		add_fields(CMD_RECON, 320, 240, 0);
		add_random(12);
		drain();

		// identity map, directed corners first
		write_reg(REG_ROW0_FIRST,  64'h0000_0000_0001_0000);
		write_reg(REG_ROW0_SECOND, 64'h0);
		write_reg(REG_ROW1_FIRST,  64'h0001_0000_0000_0000);
		write_reg(REG_ROW1_SECOND, 64'h0);
		write_reg(REG_ROW2_FIRST,  64'h0);
		write_reg(REG_ROW2_SECOND, 64'h0000_0000_0001_0000);
		write_reg(NUM_REGS, '1);           // unknown index, no effect
		write_reg(NUM_REGS + 1, 64'h1234_5678_9ABC_DEF0);
		add_fields(CMD_STORE, 0, 0, 0);
		add_fields(CMD_STORE, IMG_W - 1, IMG_H - 1, 65535);
		add_fields(CMD_STORE, IMG_W, 0, 0);        // outside, ignored
		add_fields(CMD_STORE, 0, IMG_H, 0);        // outside, ignored
		add_fields(CMD_STORE, 1023, 511, 65535);   // outside, ignored
		add_fields(CMD_RECON, 0, 0, 1);
		add_fields(CMD_RECON, 0, 0, 65535);
		add_fields(CMD_RECON, IMG_W - 1, IMG_H - 1, 1000);
		add_fields(CMD_RECON, IMG_W, 0, 1000);
		add_fields(CMD_RECON, 0, IMG_H, 1000);
		add_fields(CMD_RECON, 1023, 511, 16000);
		add_fields(CMD_RECON, 5, 7, 0);
		add_fields(CMD_STORE, 5, 7, 0);
		add_fields(CMD_RECON, 5, 7, 2500);         // reads the fresh store
		add_random(340);
		drain();

		// extreme coefficients, mostly out of frame or overflow-sized sums
		for (int k = 0; k < NUM_REGS; k++)
			write_reg(k, {extreme_coef(), extreme_coef()});
		add_random(110);
		drain();
		for (int k = 0; k < NUM_REGS; k++)
			write_reg(k, {32'($urandom), 32'($urandom)});
		add_random(110);
		drain();

		set_identity_like();
		add_random(290);
		drain();
		set_identity_like();
		add_random(300);
		drain();

		if (!failed && color_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// idle percentages: sender light / receiver heavy, then swapped, then none
	function automatic int send_idle();
		return n_in < 550 ? 11 : (n_in < 1100 ? 50 : 0);
	endfunction

	function automatic int recv_idle();
		return n_in < 550 ? 50 : (n_in < 1100 ? 11 : 0);
	endfunction

	// driver: s_tdata = pixel_x, pixel_y, depth_mm, red, green, blue, pad
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			color_of_pixel(on_bus);
			n_in++;
		end
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pixel_queue.size() && $urandom_range(99) >= send_idle()) begin
				on_bus = pixel_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= on_bus.cmd;
				s_tdata  <= {5'b0, on_bus.b, on_bus.g, on_bus.r, on_bus.depth,
				             on_bus.y, on_bus.x};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver hold-off: one long stall so the core backs up to its input
	always @(posedge clk) begin
		if (!hold_done && n_in >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_cnt  <= HOLD_CYC;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// monitor: m_tdata = out_red, out_green, out_blue; m_tuser = pixel_status
	always @(posedge clk) begin
		color_t exp_c;
		if (m_tvalid && m_tready) begin
			if (color_due.size() == 0) begin
				$error("result word with nothing expected");
				failed = 1'b1;
			end else begin
				exp_c = color_due.pop_front();
				if (m_tdata[7:0] !== exp_c.r) begin
					$error("out_red exp %0d got %0d", exp_c.r, m_tdata[7:0]);
					failed = 1'b1;
				end
				if (m_tdata[15:8] !== exp_c.g) begin
					$error("out_green exp %0d got %0d", exp_c.g, m_tdata[15:8]);
					failed = 1'b1;
				end
				if (m_tdata[23:16] !== exp_c.b) begin
					$error("out_blue exp %0d got %0d", exp_c.b, m_tdata[23:16]);
					failed = 1'b1;
				end
				if (m_tuser !== exp_c.st) begin
					$error("pixel_status exp %0d got %0d", exp_c.st, m_tuser);
					failed = 1'b1;
				end
			end
		end
		m_tready <= arst_n && hold_cnt == 0 && !(!hold_done && n_in >= HOLD_AT) &&
		            $urandom_range(99) >= recv_idle();
	end

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYC_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule
